FILE: rtl/epsc_pkg.sv
// ----------------------------------------------------------------------------
// epsc_pkg
// Shared types and constants of the encoder speed controller: field widths,
// register map, multiplier operand codes and the controller command bundle.
// ----------------------------------------------------------------------------
package epsc_pkg;

	localparam int SAMPLE_W = 12;
	localparam int COUNT_W  = 16;
	localparam int DRIVE_W  = 16;
	localparam int SPEED_W  = 31;
	localparam int GAIN_W   = 24;
	localparam int LIMIT_W  = 31;
	localparam int BASE_W   = 15;

	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 5;
	localparam int REG_IDX_W  = 3;

	localparam logic [REG_IDX_W-1:0] REG_PROP_GAIN       = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_INTEG_GAIN      = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_DERIV_GAIN      = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_INTEG_LIMIT     = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_BASE_DRIVE      = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_SPEED_PER_COUNT = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_TARGET_PER_LSB  = 3'd6;

	localparam logic [GAIN_W-1:0]  RST_PROP_GAIN       = 24'd98304;
	localparam logic [GAIN_W-1:0]  RST_INTEG_GAIN      = 24'd1966;
	localparam logic [GAIN_W-1:0]  RST_DERIV_GAIN      = 24'd26214;
	localparam logic [LIMIT_W-1:0] RST_INTEG_LIMIT     = 31'd26214400;
	localparam logic [BASE_W-1:0]  RST_BASE_DRIVE      = 15'd350;
	localparam logic [GAIN_W-1:0]  RST_SPEED_PER_COUNT = 24'd16718;
	localparam logic [GAIN_W-1:0]  RST_TARGET_PER_LSB  = 24'd4801;

	localparam int MUL_SEL_W = 3;
	localparam logic [MUL_SEL_W-1:0] MUL_TGT  = 3'd0;
	localparam logic [MUL_SEL_W-1:0] MUL_MEAS = 3'd1;
	localparam logic [MUL_SEL_W-1:0] MUL_INT  = 3'd2;
	localparam logic [MUL_SEL_W-1:0] MUL_PROP = 3'd3;
	localparam logic [MUL_SEL_W-1:0] MUL_DER  = 3'd4;

	typedef struct packed {
		logic [GAIN_W-1:0]  prop_gain;
		logic [GAIN_W-1:0]  integ_gain_per_tick;
		logic [GAIN_W-1:0]  deriv_gain_per_tick;
		logic [LIMIT_W-1:0] integ_limit;
		logic [BASE_W-1:0]  base_drive;
		logic [GAIN_W-1:0]  speed_per_count;
		logic [GAIN_W-1:0]  target_per_lsb;
	} cfg_t;

	typedef struct packed {
		logic                 accept;
		logic                 mul_en;
		logic [MUL_SEL_W-1:0] mul_sel;
		logic                 load_target;
		logic                 load_meas;
		logic                 load_integ;
		logic                 load_part;
		logic                 load_sum;
		logic                 load_out;
	} cmd_t;

endpackage

FILE: rtl/epsc_if.sv
// ----------------------------------------------------------------------------
// epsc_if
// Valid/ready channels of the speed controller: one tick item in, one
// result item out.
// ----------------------------------------------------------------------------
interface epsc_tick_if;
	logic                           valid;
	logic                           ready;
	logic [epsc_pkg::SAMPLE_W-1:0]  adc_sample;
	logic [epsc_pkg::COUNT_W-1:0]   encoder_count;

	modport source (output valid, output adc_sample, output encoder_count, input ready);
	modport sink   (input valid, input adc_sample, input encoder_count, output ready);
endinterface

interface epsc_result_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [epsc_pkg::DRIVE_W-1:0]  pwm_drive;
	logic [epsc_pkg::SPEED_W-1:0]         target_speed;
	logic [epsc_pkg::SPEED_W-1:0]         measured_speed;

	modport source (output valid, output pwm_drive, output target_speed,
		output measured_speed, input ready);
	modport sink   (input valid, input pwm_drive, input target_speed,
		input measured_speed, output ready);
endinterface

FILE: rtl/epsc_regs.sv
// ----------------------------------------------------------------------------
// epsc_regs
// APB-style configuration registers: gains, integral clamp, base drive and
// the two speed scale factors.
// ----------------------------------------------------------------------------
module epsc_regs (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [epsc_pkg::APB_ADDR_W-1:0]     paddr,
	input  logic [epsc_pkg::APB_DATA_W-1:0]     pwdata,
	output logic [epsc_pkg::APB_DATA_W-1:0]     prdata,
	output logic                                pready,
	output epsc_pkg::cfg_t                      cfg
);

	epsc_pkg::cfg_t                     cfg_q;
	logic [epsc_pkg::REG_IDX_W-1:0]     idx;
	logic                               wr_en;

	assign idx    = paddr[epsc_pkg::APB_ADDR_W-1:2];
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.prop_gain           <= epsc_pkg::RST_PROP_GAIN;
			cfg_q.integ_gain_per_tick <= epsc_pkg::RST_INTEG_GAIN;
			cfg_q.deriv_gain_per_tick <= epsc_pkg::RST_DERIV_GAIN;
			cfg_q.integ_limit         <= epsc_pkg::RST_INTEG_LIMIT;
			cfg_q.base_drive          <= epsc_pkg::RST_BASE_DRIVE;
			cfg_q.speed_per_count     <= epsc_pkg::RST_SPEED_PER_COUNT;
			cfg_q.target_per_lsb      <= epsc_pkg::RST_TARGET_PER_LSB;
		end else if (wr_en) begin
			unique case (idx)
				epsc_pkg::REG_PROP_GAIN:
					cfg_q.prop_gain <= pwdata[epsc_pkg::GAIN_W-1:0];
				epsc_pkg::REG_INTEG_GAIN:
					cfg_q.integ_gain_per_tick <= pwdata[epsc_pkg::GAIN_W-1:0];
				epsc_pkg::REG_DERIV_GAIN:
					cfg_q.deriv_gain_per_tick <= pwdata[epsc_pkg::GAIN_W-1:0];
				epsc_pkg::REG_INTEG_LIMIT:
					cfg_q.integ_limit <= pwdata[epsc_pkg::LIMIT_W-1:0];
				epsc_pkg::REG_BASE_DRIVE:
					cfg_q.base_drive <= pwdata[epsc_pkg::BASE_W-1:0];
				epsc_pkg::REG_SPEED_PER_COUNT:
					cfg_q.speed_per_count <= pwdata[epsc_pkg::GAIN_W-1:0];
				epsc_pkg::REG_TARGET_PER_LSB:
					cfg_q.target_per_lsb <= pwdata[epsc_pkg::GAIN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			epsc_pkg::REG_PROP_GAIN:
				prdata = epsc_pkg::APB_DATA_W'(cfg_q.prop_gain);
			epsc_pkg::REG_INTEG_GAIN:
				prdata = epsc_pkg::APB_DATA_W'(cfg_q.integ_gain_per_tick);
			epsc_pkg::REG_DERIV_GAIN:
				prdata = epsc_pkg::APB_DATA_W'(cfg_q.deriv_gain_per_tick);
			epsc_pkg::REG_INTEG_LIMIT:
				prdata = epsc_pkg::APB_DATA_W'(cfg_q.integ_limit);
			epsc_pkg::REG_BASE_DRIVE:
				prdata = epsc_pkg::APB_DATA_W'(cfg_q.base_drive);
			epsc_pkg::REG_SPEED_PER_COUNT:
				prdata = epsc_pkg::APB_DATA_W'(cfg_q.speed_per_count);
			epsc_pkg::REG_TARGET_PER_LSB:
				prdata = epsc_pkg::APB_DATA_W'(cfg_q.target_per_lsb);
			default:
				prdata = '0;
		endcase
	end

endmodule

FILE: rtl/epsc_ctrl.sv
// ----------------------------------------------------------------------------
// epsc_ctrl
// Sequencer of one control tick: steps the shared multiplier through the
// five products and owns the input and output handshakes.
// ----------------------------------------------------------------------------
module epsc_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	output epsc_pkg::cmd_t cmd
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_MT   = 4'd1;
	localparam logic [3:0] S_MM   = 4'd2;
	localparam logic [3:0] S_ERR  = 4'd3;
	localparam logic [3:0] S_MI   = 4'd4;
	localparam logic [3:0] S_MP   = 4'd5;
	localparam logic [3:0] S_MD   = 4'd6;
	localparam logic [3:0] S_DT   = 4'd7;
	localparam logic [3:0] S_FIN  = 4'd8;

	logic [3:0] state_q;
	logic [3:0] state_nxt;
	logic       out_valid_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_nxt  = S_MT;
				end
			end
			S_MT: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = epsc_pkg::MUL_TGT;
				state_nxt   = S_MM;
			end
			S_MM: begin
				cmd.mul_en      = 1'b1;
				cmd.mul_sel     = epsc_pkg::MUL_MEAS;
				cmd.load_target = 1'b1;
				state_nxt       = S_ERR;
			end
			S_ERR: begin
				cmd.load_meas = 1'b1;
				state_nxt     = S_MI;
			end
			S_MI: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = epsc_pkg::MUL_INT;
				state_nxt   = S_MP;
			end
			S_MP: begin
				cmd.mul_en     = 1'b1;
				cmd.mul_sel    = epsc_pkg::MUL_PROP;
				cmd.load_integ = 1'b1;
				state_nxt      = S_MD;
			end
			S_MD: begin
				cmd.mul_en    = 1'b1;
				cmd.mul_sel   = epsc_pkg::MUL_DER;
				cmd.load_part = 1'b1;
				state_nxt     = S_DT;
			end
			S_DT: begin
				cmd.load_sum = 1'b1;
				state_nxt    = S_FIN;
			end
			S_FIN: begin
				if (!out_valid_q || out_ready) begin
					cmd.load_out = 1'b1;
					state_nxt    = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

FILE: rtl/epsc_dp.sv
// ----------------------------------------------------------------------------
// epsc_dp
// Datapath: counter difference, one shared 33 x 25 signed multiplier,
// clamped integral, derivative on measurement and drive saturation.
// ----------------------------------------------------------------------------
module epsc_dp #(
	parameter int COUNTER_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  epsc_pkg::cfg_t                      cfg,
	input  epsc_pkg::cmd_t                      cmd,
	input  logic [epsc_pkg::SAMPLE_W-1:0]       adc_sample,
	input  logic [epsc_pkg::COUNT_W-1:0]        encoder_count,
	output logic signed [epsc_pkg::DRIVE_W-1:0] pwm_drive,
	output logic [epsc_pkg::SPEED_W-1:0]        target_speed,
	output logic [epsc_pkg::SPEED_W-1:0]        measured_speed
);

	localparam int OPA_W  = 33;
	localparam int OPB_W  = epsc_pkg::GAIN_W + 1;
	localparam int PROD_W = OPA_W + OPB_W;
	localparam int TERM_W = PROD_W - 16;
	localparam int INTS_W = TERM_W + 1;
	localparam int SUM_W  = TERM_W + 3;
	localparam int ERR_W  = epsc_pkg::SPEED_W + 1;
	localparam int WHOLE_W = SUM_W - 16;

	logic [epsc_pkg::SAMPLE_W-1:0]  sample_q;
	logic [COUNTER_BITS-1:0]        mag_q;
	logic [COUNTER_BITS-1:0]        prev_count_q;
	logic signed [PROD_W-1:0]       prod_q;
	logic [epsc_pkg::SPEED_W-1:0]   target_q;
	logic [epsc_pkg::SPEED_W-1:0]   measured_q;
	logic [epsc_pkg::SPEED_W-1:0]   prev_speed_q;
	logic signed [ERR_W-1:0]        error_q;
	logic signed [ERR_W-1:0]        derr_q;
	logic signed [ERR_W-1:0]        integ_q;
	logic signed [SUM_W-1:0]        part_q;
	logic signed [SUM_W-1:0]        sum_q;

	logic [COUNTER_BITS-1:0]        cnt;
	logic [COUNTER_BITS-1:0]        diff;
	logic signed [OPA_W-1:0]        opa;
	logic signed [OPB_W-1:0]        opb;
	logic signed [TERM_W-1:0]       term;
	logic [epsc_pkg::SPEED_W-1:0]   prod_sat;
	logic signed [INTS_W-1:0]       integ_sum;
	logic signed [INTS_W-1:0]       lim;
	logic signed [INTS_W-1:0]       integ_nxt;
	logic [SUM_W-1:0]               sum_abs;
	logic [WHOLE_W-1:0]             whole;
	logic [epsc_pkg::DRIVE_W-1:0]   drive_mag;
	logic signed [epsc_pkg::DRIVE_W-1:0] drive;

	function automatic logic [epsc_pkg::SPEED_W-1:0] sat_speed(input logic signed [PROD_W-1:0] p);
		if (p > $signed({{(PROD_W-epsc_pkg::SPEED_W){1'b0}}, {epsc_pkg::SPEED_W{1'b1}}})) begin
			return '1;
		end
		return p[epsc_pkg::SPEED_W-1:0];
	endfunction

	// counter step magnitude, half range counts as negative
	assign cnt  = COUNTER_BITS'(encoder_count);
	assign diff = cnt - prev_count_q;

	always_comb begin
		unique case (cmd.mul_sel)
			epsc_pkg::MUL_TGT: begin
				opa = OPA_W'(sample_q);
				opb = {1'b0, cfg.target_per_lsb};
			end
			epsc_pkg::MUL_MEAS: begin
				opa = OPA_W'(mag_q);
				opb = {1'b0, cfg.speed_per_count};
			end
			epsc_pkg::MUL_INT: begin
				opa = {error_q[ERR_W-1], error_q};
				opb = {1'b0, cfg.integ_gain_per_tick};
			end
			epsc_pkg::MUL_PROP: begin
				opa = {error_q[ERR_W-1], error_q};
				opb = {1'b0, cfg.prop_gain};
			end
			epsc_pkg::MUL_DER: begin
				opa = {derr_q[ERR_W-1], derr_q};
				opb = {1'b0, cfg.deriv_gain_per_tick};
			end
			default: begin
				opa = '0;
				opb = '0;
			end
		endcase
	end

	// floor shift of the gain product
	assign term     = $signed(prod_q[PROD_W-1:16]);
	assign prod_sat = sat_speed(prod_q);

	assign integ_sum = {{(INTS_W-ERR_W){integ_q[ERR_W-1]}}, integ_q} + {term[TERM_W-1], term};
	assign lim       = $signed({{(INTS_W-epsc_pkg::LIMIT_W){1'b0}}, cfg.integ_limit});

	always_comb begin
		if (integ_sum > lim) begin
			integ_nxt = lim;
		end else if (integ_sum < -lim) begin
			integ_nxt = -lim;
		end else begin
			integ_nxt = integ_sum;
		end
	end

	// truncate toward zero, then saturate
	assign sum_abs = sum_q[SUM_W-1] ? $unsigned(-sum_q) : $unsigned(sum_q);
	assign whole   = sum_abs[SUM_W-1:16];

	always_comb begin
		if (sum_q[SUM_W-1]) begin
			if (whole > WHOLE_W'(32768)) begin
				drive_mag = 16'h8000;
			end else begin
				drive_mag = whole[epsc_pkg::DRIVE_W-1:0];
			end
			drive = $signed(-drive_mag);
		end else begin
			if (whole > WHOLE_W'(32767)) begin
				drive_mag = 16'h7fff;
			end else begin
				drive_mag = whole[epsc_pkg::DRIVE_W-1:0];
			end
			drive = $signed(drive_mag);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_count_q <= '0;
			prev_speed_q <= '0;
			integ_q      <= '0;
		end else begin
			if (cmd.accept) begin
				prev_count_q <= cnt;
			end
			if (cmd.load_meas) begin
				prev_speed_q <= prod_sat;
			end
			if (cmd.load_integ) begin
				integ_q <= integ_nxt[ERR_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			sample_q <= adc_sample;
			mag_q    <= diff[COUNTER_BITS-1] ? -diff : diff;
		end
		if (cmd.mul_en) begin
			prod_q <= opa * opb;
		end
		if (cmd.load_target) begin
			target_q <= prod_sat;
		end
		if (cmd.load_meas) begin
			measured_q <= prod_sat;
			error_q    <= $signed({1'b0, target_q}) - $signed({1'b0, prod_sat});
			derr_q     <= $signed({1'b0, prod_sat}) - $signed({1'b0, prev_speed_q});
		end
		if (cmd.load_part) begin
			part_q <= $signed({{(SUM_W-epsc_pkg::BASE_W-16){1'b0}}, cfg.base_drive, 16'h0000})
				+ {{(SUM_W-TERM_W){term[TERM_W-1]}}, term}
				+ {{(SUM_W-ERR_W){integ_q[ERR_W-1]}}, integ_q};
		end
		if (cmd.load_sum) begin
			sum_q <= part_q - {{(SUM_W-TERM_W){term[TERM_W-1]}}, term};
		end
		if (cmd.load_out) begin
			pwm_drive      <= drive;
			target_speed   <= target_q;
			measured_speed <= measured_q;
		end
	end

endmodule

FILE: rtl/encoder_pid_speed_controller.sv
// ----------------------------------------------------------------------------
// encoder_pid_speed_controller
// PID speed loop with derivative on measurement, fed by a setpoint sample and
// a free-running quadrature counter once per control tick.
// ----------------------------------------------------------------------------
// One tick item is taken while the sequencer is idle; its result is registered
// once the sequencer has stepped through its states and the result register is
// no longer held by a stalled consumer, and a new item can be taken in the cycle
// after. The pace is set by the single 33 x 25 signed multiplier, used in turn
// for target speed, measured speed, the integral increment, the proportional
// term and the derivative term. A finished result waits in its own register
// while the next item is accepted.
module encoder_pid_speed_controller #(
	parameter int COUNTER_BITS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	epsc_tick_if.sink                       tick,
	epsc_result_if.source                   result,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [epsc_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [epsc_pkg::APB_DATA_W-1:0] pwdata,
	output logic [epsc_pkg::APB_DATA_W-1:0] prdata,
	output logic                            pready
);

	epsc_pkg::cfg_t cfg;
	epsc_pkg::cmd_t cmd;

	epsc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	epsc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (tick.valid),
		.in_ready  (tick.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.cmd       (cmd)
	);

	epsc_dp #(
		.COUNTER_BITS (COUNTER_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg),
		.cmd            (cmd),
		.adc_sample     (tick.adc_sample),
		.encoder_count  (tick.encoder_count),
		.pwm_drive      (result.pwm_drive),
		.target_speed   (result.target_speed),
		.measured_speed (result.measured_speed)
	);

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the encoder PID speed controller. A queue-fed
// driver streams tick items with random gaps, a monitor predicts each result
// item from its own fixed-point copy of the control law and compares it field
// by field, and the register port is rewritten between batches, from zero and
// full-scale settings to gains near the nominal ones.
// ----------------------------------------------------------------------------
module testbench;
	import epsc_pkg::*;

	typedef struct packed {
		logic [SAMPLE_W-1:0] adc_sample;
		logic [COUNT_W-1:0]  encoder_count;
	} tick_item_t;

	typedef struct packed {
		logic signed [DRIVE_W-1:0] pwm_drive;
		logic [SPEED_W-1:0]        target_speed;
		logic [SPEED_W-1:0]        measured_speed;
	} drive_result_t;

	typedef enum {SET_LOW, SET_HIGH, SET_NEAR, SET_ANY, SET_MIX} setting_kind_t;

	localparam logic [REG_IDX_W-1:0] REG_UNMAPPED = 3'd7;
	localparam longint SPEED_TOP    = 64'sd2147483647;
	localparam longint DRIVE_TOP    = 32767;
	localparam longint DRIVE_BOTTOM = -32768;

	logic                  clk;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	epsc_tick_if   tick_ch();
	epsc_result_if result_ch();

	encoder_pid_speed_controller u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.tick    (tick_ch),
		.result  (result_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	cfg_t                shadow_cfg;
	logic [COUNT_W-1:0]  last_count = '0;
	longint              integ_sum = 0;
	longint              last_speed = 0;

	tick_item_t          tick_items_pending[$];
	drive_result_t       drive_expected[$];
	tick_item_t          tick_next;
	drive_result_t       drive_front;
	int                  ticks_queued = 0;
	int                  ticks_taken = 0;
	bit                  tick_fired = 1'b0;
	int                  tick_gap = 0;
	int                  ready_hold = 0;
	int                  tick_gap_pct = 0;
	int                  ready_gap_pct = 0;
	int                  mismatches = 0;
	logic [SAMPLE_W-1:0] gen_sample = '0;
	logic [COUNT_W-1:0]  gen_count = '0;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic int reg_width(logic [REG_IDX_W-1:0] r);
		case (r)
			REG_INTEG_LIMIT: return LIMIT_W;
			REG_BASE_DRIVE:  return BASE_W;
			default:         return GAIN_W;
		endcase
	endfunction

	function automatic logic [APB_DATA_W-1:0] reg_reset(logic [REG_IDX_W-1:0] r);
		case (r)
			REG_PROP_GAIN:       return APB_DATA_W'(RST_PROP_GAIN);
			REG_INTEG_GAIN:      return APB_DATA_W'(RST_INTEG_GAIN);
			REG_DERIV_GAIN:      return APB_DATA_W'(RST_DERIV_GAIN);
			REG_INTEG_LIMIT:     return APB_DATA_W'(RST_INTEG_LIMIT);
			REG_BASE_DRIVE:      return APB_DATA_W'(RST_BASE_DRIVE);
			REG_SPEED_PER_COUNT: return APB_DATA_W'(RST_SPEED_PER_COUNT);
			REG_TARGET_PER_LSB:  return APB_DATA_W'(RST_TARGET_PER_LSB);
			default:             return '0;
		endcase
	endfunction

	function automatic void shadow_store(logic [REG_IDX_W-1:0] r, logic [APB_DATA_W-1:0] data);
		case (r)
			REG_PROP_GAIN:       shadow_cfg.prop_gain = data[GAIN_W-1:0];
			REG_INTEG_GAIN:      shadow_cfg.integ_gain_per_tick = data[GAIN_W-1:0];
			REG_DERIV_GAIN:      shadow_cfg.deriv_gain_per_tick = data[GAIN_W-1:0];
			REG_INTEG_LIMIT:     shadow_cfg.integ_limit = data[LIMIT_W-1:0];
			REG_BASE_DRIVE:      shadow_cfg.base_drive = data[BASE_W-1:0];
			REG_SPEED_PER_COUNT: shadow_cfg.speed_per_count = data[GAIN_W-1:0];
			REG_TARGET_PER_LSB:  shadow_cfg.target_per_lsb = data[GAIN_W-1:0];
			default: ;
		endcase
	endfunction

	function automatic logic [APB_DATA_W-1:0] shadow_value(logic [REG_IDX_W-1:0] r);
		case (r)
			REG_PROP_GAIN:       return APB_DATA_W'(shadow_cfg.prop_gain);
			REG_INTEG_GAIN:      return APB_DATA_W'(shadow_cfg.integ_gain_per_tick);
			REG_DERIV_GAIN:      return APB_DATA_W'(shadow_cfg.deriv_gain_per_tick);
			REG_INTEG_LIMIT:     return APB_DATA_W'(shadow_cfg.integ_limit);
			REG_BASE_DRIVE:      return APB_DATA_W'(shadow_cfg.base_drive);
			REG_SPEED_PER_COUNT: return APB_DATA_W'(shadow_cfg.speed_per_count);
			REG_TARGET_PER_LSB:  return APB_DATA_W'(shadow_cfg.target_per_lsb);
			default:             return '0;
		endcase
	endfunction

	// q8.16 gain product, floor of the shifted result
	function automatic longint scale_gain(longint v, logic [GAIN_W-1:0] gain);
		longint g;
		g = gain;
		return (v * g) >>> 16;
	endfunction

	function automatic drive_result_t predict_tick(tick_item_t t);
		logic [COUNT_W-1:0] diff;
		longint             steps;
		longint             target;
		longint             measured;
		longint             err;
		longint             lim;
		longint             p_term;
		longint             d_term;
		longint             sum;
		longint             whole;
		drive_result_t      r;
		diff = t.encoder_count - last_count;
		steps = diff;
		// half range and above counts as a reverse step
		if (diff[COUNT_W-1])
			steps = 65536 - steps;
		target = t.adc_sample;
		target = target * shadow_cfg.target_per_lsb;
		if (target > SPEED_TOP)
			target = SPEED_TOP;
		measured = steps * shadow_cfg.speed_per_count;
		if (measured > SPEED_TOP)
			measured = SPEED_TOP;
		err = target - measured;
		lim = shadow_cfg.integ_limit;
		integ_sum = integ_sum + scale_gain(err, shadow_cfg.integ_gain_per_tick);
		if (integ_sum > lim)
			integ_sum = lim;
		if (integ_sum < -lim)
			integ_sum = -lim;
		p_term = scale_gain(err, shadow_cfg.prop_gain);
		d_term = scale_gain(measured - last_speed, shadow_cfg.deriv_gain_per_tick);
		last_speed = measured;
		last_count = t.encoder_count;
		sum = shadow_cfg.base_drive;
		sum = (sum <<< 16) + p_term + integ_sum - d_term;
		whole = (sum >= 0) ? (sum >>> 16) : -((-sum) >>> 16);
		if (whole > DRIVE_TOP)
			whole = DRIVE_TOP;
		if (whole < DRIVE_BOTTOM)
			whole = DRIVE_BOTTOM;
		r.pwm_drive = whole[DRIVE_W-1:0];
		r.target_speed = target[SPEED_W-1:0];
		r.measured_speed = measured[SPEED_W-1:0];
		return r;
	endfunction

	function automatic logic [APB_DATA_W-1:0] pick_setting(logic [REG_IDX_W-1:0] r,
		setting_kind_t kind);
		logic [APB_DATA_W-1:0] mask;
		logic [APB_DATA_W-1:0] val;
		mask = (32'h1 << reg_width(r)) - 32'h1;
		case (kind)
			SET_LOW:  val = '0;
			SET_HIGH: val = mask;
			SET_NEAR: val = ((reg_reset(r) * $urandom_range(1, 12)) >> 2) & mask;
			default:  val = $urandom() & mask;
		endcase
		// junk above the field must be dropped by the block
		return ($urandom() & ~mask) | val;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch: %s got %0d want %0d", what, got, want);
		mismatches++;
	endtask

	function automatic void queue_tick(logic [SAMPLE_W-1:0] s, logic [COUNT_W-1:0] c);
		tick_item_t t;
		t.adc_sample = s;
		t.encoder_count = c;
		tick_items_pending.push_back(t);
		ticks_queued++;
	endfunction

	// mostly steady setpoints and smooth counter motion, with jumps and noise
	function automatic void queue_random_ticks(int n, int span);
		int roll;
		int delta;
		for (int i = 0; i < n; i++) begin
			roll = $urandom_range(0, 99);
			delta = 0;
			if ($urandom_range(0, 9) == 0)
				gen_sample = SAMPLE_W'($urandom_range(0, 4095));
			if (roll < 70) begin
				delta = $urandom_range(0, 2 * span) - span;
			end else if (roll < 80) begin
				delta = $urandom();
			end else if (roll < 90) begin
				case ($urandom_range(0, 3))
					0: delta = 32768;
					1: delta = 32767;
					2: delta = -32767;
					default: delta = 0;
				endcase
			end else begin
				gen_sample = $urandom_range(0, 1) ? '1 : '0;
				delta = $urandom_range(0, 2) - 1;
			end
			gen_count = gen_count + delta[COUNT_W-1:0];
			queue_tick(gen_sample, gen_count);
		end
	endfunction

	task automatic apb_write(logic [REG_IDX_W-1:0] r, logic [APB_DATA_W-1:0] data);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {r, 2'b00};
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		shadow_store(r, data);
	endtask

	task automatic check_all_regs();
		logic [REG_IDX_W-1:0] r;
		logic [APB_DATA_W-1:0] got;
		for (r = REG_PROP_GAIN; r <= REG_TARGET_PER_LSB; r++) begin
			@(negedge clk);
			psel <= 1'b1;
			penable <= 1'b0;
			pwrite <= 1'b0;
			paddr <= {r, 2'b00};
			@(negedge clk);
			penable <= 1'b1;
			do @(posedge clk); while (!pready);
			got = prdata;
			@(negedge clk);
			psel <= 1'b0;
			penable <= 1'b0;
			if (got !== shadow_value(r))
				report_mismatch($sformatf("register %0d readback", r), got, shadow_value(r));
		end
	endtask

	task automatic load_setting(setting_kind_t kind);
		logic [REG_IDX_W-1:0] r;
		setting_kind_t k;
		for (r = REG_PROP_GAIN; r <= REG_TARGET_PER_LSB; r++) begin
			k = (kind == SET_MIX) ? setting_kind_t'($urandom_range(0, 3)) : kind;
			apb_write(r, pick_setting(r, k));
		end
		check_all_regs();
	endtask

	task automatic run_batch();
		while (ticks_taken != ticks_queued || drive_expected.size() != 0)
			@(posedge clk);
	endtask

	// tick item driver
	always @(negedge clk) begin
		if (!arst_n) begin
			tick_ch.valid <= 1'b0;
		end else if (!tick_ch.valid || tick_fired) begin
			if (tick_gap != 0) begin
				tick_ch.valid <= 1'b0;
				tick_gap = tick_gap - 1;
			end else if (tick_items_pending.size() != 0) begin
				tick_next = tick_items_pending.pop_front();
				tick_ch.valid <= 1'b1;
				tick_ch.adc_sample <= tick_next.adc_sample;
				tick_ch.encoder_count <= tick_next.encoder_count;
				if (tick_gap_pct != 0 && $urandom_range(0, 99) < tick_gap_pct)
					tick_gap = $urandom_range(1, 5);
			end else begin
				tick_ch.valid <= 1'b0;
			end
		end
	end

	// result back-pressure
	always @(negedge clk) begin
		if (ready_hold != 0) begin
			result_ch.ready <= 1'b0;
			ready_hold = ready_hold - 1;
		end else begin
			result_ch.ready <= 1'b1;
			if (ready_gap_pct != 0 && $urandom_range(0, 99) < ready_gap_pct)
				ready_hold = $urandom_range(1, 5);
		end
	end

	// monitor and checker
	always @(posedge clk) begin
		tick_fired <= tick_ch.valid && tick_ch.ready;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (drive_expected.size() == 0) begin
				report_mismatch("result item with none pending", 0, 0);
			end else begin
				drive_front = drive_expected.pop_front();
				if (result_ch.pwm_drive !== drive_front.pwm_drive)
					report_mismatch("pwm_drive", result_ch.pwm_drive, drive_front.pwm_drive);
				if (result_ch.target_speed !== drive_front.target_speed)
					report_mismatch("target_speed", result_ch.target_speed,
						drive_front.target_speed);
				if (result_ch.measured_speed !== drive_front.measured_speed)
					report_mismatch("measured_speed", result_ch.measured_speed,
						drive_front.measured_speed);
			end
		end
		if (arst_n && tick_ch.valid && tick_ch.ready) begin
			drive_expected.push_back(predict_tick({tick_ch.adc_sample, tick_ch.encoder_count}));
			ticks_taken <= ticks_taken + 1;
		end
	end

	initial begin
		#2_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		logic [REG_IDX_W-1:0] r;
		setting_kind_t kind;
		int span;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		tick_ch.valid = 1'b0;
		tick_ch.adc_sample = '0;
		tick_ch.encoder_count = '0;
		result_ch.ready = 1'b0;
		for (r = REG_PROP_GAIN; r <= REG_TARGET_PER_LSB; r++)
			shadow_store(r, reg_reset(r));
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		check_all_regs();

		// nominal gains: zero step, forward, reverse, half range, counter wrap
		tick_gap_pct = 20;
		ready_gap_pct = 20;
		queue_tick(12'd0, 16'd0);
		queue_tick(12'd4095, 16'd0);
		queue_tick(12'd4095, 16'd100);
		queue_tick(12'd2048, 16'd50);
		queue_tick(12'd0, 16'd32818);
		queue_tick(12'd4095, 16'd50);
		queue_tick(12'd4095, 16'd32817);
		queue_tick(12'd1, 16'd65500);
		queue_tick(12'd4095, 16'd30);
		queue_tick(12'd4095, 16'd65500);
		queue_tick(12'd4095, 16'd65535);
		queue_tick(12'd0, 16'd65535);
		run_batch();

		// full-scale gains: speed saturation, integral clamp, drive saturation
		apb_write(REG_PROP_GAIN, 32'h00FF_FFFF);
		apb_write(REG_INTEG_GAIN, 32'hFFFF_FFFF);
		apb_write(REG_DERIV_GAIN, 32'h00FF_FFFF);
		apb_write(REG_INTEG_LIMIT, 32'd1000);
		apb_write(REG_BASE_DRIVE, 32'hFFFF_7FFF);
		apb_write(REG_TARGET_PER_LSB, 32'h00FF_FFFF);
		apb_write(REG_UNMAPPED, $urandom());
		check_all_regs();
		queue_tick(12'd4095, 16'd65535);
		queue_tick(12'd4095, 16'd65535);
		queue_tick(12'd0, 16'd65535);
		queue_tick(12'd0, 16'd35000);
		queue_tick(12'd0, 16'd35000);
		queue_tick(12'd4095, 16'd2000);
		queue_tick(12'd0, 16'd2000);
		queue_tick(12'd2000, 16'd2001);
		queue_tick(12'd2000, 16'd2001);
		queue_tick(12'd0, 16'd0);
		run_batch();

		for (int ph = 0; ph < 10; ph++) begin
			case (ph)
				0:       kind = SET_LOW;
				1:       kind = SET_HIGH;
				4, 6, 8: kind = SET_MIX;
				7:       kind = SET_ANY;
				default: kind = SET_NEAR;
			endcase
			case (ph % 4)
				0:       span = 4;
				1:       span = 400;
				2:       span = 3000;
				default: span = 24000;
			endcase
			load_setting(kind);
			// every third batch and the closing one run without gaps
			tick_gap_pct = (ph % 3 == 0 || ph == 9) ? 0 : 25;
			ready_gap_pct = (ph % 3 == 0 || ph == 9) ? 0 : 30;
			queue_random_ticks(170, span);
			run_batch();
		end

		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
